>>> hw/rtl/cpu_alu_flags_8bit_defines.svh
// ----------------------------------------------------------------------------
// cpu_alu_flags_8bit_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_FLAGS_8BIT_DEFINES_SVH
`define CPU_ALU_FLAGS_8BIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CAF8_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("caf8 check failed");

// Next-cycle implication, disabled while reset is high.
`define CAF8_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("caf8 check failed");

`endif

>>> hw/rtl/caf8_pkg.sv
// ----------------------------------------------------------------------------
// caf8_pkg
// Operation codes and flag bit positions of the 8-bit ALU and flag unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package caf8_pkg;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_CMP   = 4'd2,
    KIND_INC   = 4'd3,
    KIND_DEC   = 4'd4,
    KIND_XOR   = 4'd5,
    KIND_SWAP  = 4'd6,
    KIND_RL    = 4'd7,
    KIND_BIT   = 4'd8,
    KIND_ADD16 = 4'd9
  } kind_t;

  // Flag nibble layout: Z N H C
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

endpackage

`default_nettype wire

>>> hw/rtl/cpu_alu_flags_8bit.sv
// ----------------------------------------------------------------------------
// cpu_alu_flags_8bit
// Arithmetic and flag unit of an 8-bit handheld-console processor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with kind, operand_a, operand_b,
//   bit_index and flags_in. A request is taken at a rising edge where
//   in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with result and flags_out. One
//   result leaves for every request, in request order.
//   Path: the request lands in the input register, the ALU
//   and flag logic sit between that register and the result register.
//   Throughput: one request per cycle when out_stall is low, set by the
//   single ALU pass between the two registers; while a finished result
//   waits, the input register takes a request only if it is empty.
//   Stall: while out_stall holds a valid result, the result and flags stay
//   put; in_stall rises only once the input register is also full, so up
//   to two requests are held inside.
//   Reset (rst, synchronous, active high) empties both stages; no result
//   is shown until a new request arrives. No configuration, no state
//   kept between requests.
//   Unused kinds 10..15 pass operand_a and flags_in through unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_flags_8bit
  import caf8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  kind,
  input  wire logic [15:0] operand_a,
  input  wire logic [15:0] operand_b,
  input  wire logic [2:0]  bit_index,
  input  wire logic [3:0]  flags_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      result,
  output logic [3:0]       flags_out
);

  // Input register stage
  logic        s1_valid;
  logic [3:0]  s1_kind;
  logic [15:0] s1_a;
  logic [15:0] s1_b;
  logic [2:0]  s1_idx;
  logic [3:0]  s1_flags;

  // Handshake control
  logic out_ready;
  logic s1_ready;
  logic s1_move;

  // ALU outputs
  logic [15:0] result_next;
  logic [3:0]  flags_next;

  // Result register may load when empty or being drained this cycle.
  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_kind  <= kind;
      s1_a     <= operand_a;
      s1_b     <= operand_b;
      s1_idx   <= bit_index;
      s1_flags <= flags_in;
    end
  end

  // ALU datapath
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [8:0]  add9;
  logic [4:0]  add_lo;
  logic [8:0]  sub9;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  xor8;
  logic [7:0]  swap8;
  logic [7:0]  rl8;
  logic [16:0] add17;
  logic [12:0] add16_lo;
  logic        half_borrow;

  always_comb begin
    a8          = s1_a[7:0];
    b8          = s1_b[7:0];
    add9        = {1'b0, a8} + {1'b0, b8};
    add_lo      = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
    sub9        = {1'b0, a8} - {1'b0, b8};
    half_borrow = (b8[3:0] > a8[3:0]);
    inc8        = a8 + 8'd1;
    dec8        = a8 - 8'd1;
    xor8        = a8 ^ b8;
    swap8       = {a8[3:0], a8[7:4]};
    rl8         = {a8[6:0], s1_flags[FLAG_C]};
    add17       = {1'b0, s1_a} + {1'b0, s1_b};
    add16_lo    = {1'b0, s1_a[11:0]} + {1'b0, s1_b[11:0]};

    result_next = s1_a;
    flags_next  = s1_flags;

    case (s1_kind)
      KIND_ADD: begin
        result_next         = {8'h00, add9[7:0]};
        flags_next          = 4'b0000;
        flags_next[FLAG_Z]  = (add9[7:0] == 8'h00);
        flags_next[FLAG_H]  = add_lo[4];
        flags_next[FLAG_C]  = add9[8];
      end
      KIND_SUB, KIND_CMP: begin
        // compare sets the same flags but leaves the operand alone
        if (s1_kind == KIND_SUB) begin
          result_next = {8'h00, sub9[7:0]};
        end
        flags_next          = 4'b0000;
        flags_next[FLAG_Z]  = (sub9[7:0] == 8'h00);
        flags_next[FLAG_N]  = 1'b1;
        flags_next[FLAG_H]  = half_borrow;
        flags_next[FLAG_C]  = sub9[8];
      end
      KIND_INC: begin
        result_next         = {8'h00, inc8};
        flags_next[FLAG_Z]  = (inc8 == 8'h00);
        flags_next[FLAG_N]  = 1'b0;
        flags_next[FLAG_H]  = (a8[3:0] == 4'hF);
      end
      KIND_DEC: begin
        result_next         = {8'h00, dec8};
        flags_next[FLAG_Z]  = (dec8 == 8'h00);
        flags_next[FLAG_N]  = 1'b1;
        flags_next[FLAG_H]  = (a8[3:0] == 4'h0);
      end
      KIND_XOR: begin
        result_next         = {8'h00, xor8};
        flags_next          = 4'b0000;
        flags_next[FLAG_Z]  = (xor8 == 8'h00);
      end
      KIND_SWAP: begin
        result_next         = {8'h00, swap8};
        flags_next          = 4'b0000;
        flags_next[FLAG_Z]  = (swap8 == 8'h00);
      end
      KIND_RL: begin
        result_next         = {8'h00, rl8};
        flags_next          = 4'b0000;
        flags_next[FLAG_C]  = a8[7];
      end
      KIND_BIT: begin
        flags_next[FLAG_Z]  = !a8[s1_idx];
        flags_next[FLAG_N]  = 1'b0;
        flags_next[FLAG_H]  = 1'b1;
      end
      KIND_ADD16: begin
        result_next         = add17[15:0];
        flags_next[FLAG_N]  = 1'b0;
        flags_next[FLAG_H]  = add16_lo[12];
        flags_next[FLAG_C]  = add17[16];
      end
      default: begin
        result_next = s1_a;
        flags_next  = s1_flags;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result    <= result_next;
      flags_out <= flags_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/caf8_checker.sv
// ----------------------------------------------------------------------------
// caf8_checker
// Port-level checks on the ALU flag unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cpu_alu_flags_8bit_defines.svh"

module caf8_checker
  import caf8_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [3:0]  kind,
  input wire logic [15:0] operand_a,
  input wire logic [15:0] operand_b,
  input wire logic [2:0]  bit_index,
  input wire logic [3:0]  flags_in,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] result,
  input wire logic [3:0]  flags_out
);

  // held result does not move
  `CAF8_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(result) && $stable(flags_out))

  // input backs up only behind a blocked output
  `CAF8_ASSERT_SAME(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // accepted request passes from the input register to the result register when the output drains
  `CAF8_ASSERT_NEXT(a_latency, clk, rst, $past(in_valid && !in_stall) && !out_stall, out_valid)

  // compare leaves the operand as the result
  `CAF8_ASSERT_NEXT(a_cmp_keeps_a, clk, rst, $past(in_valid && !in_stall && kind == KIND_CMP) && !out_stall, out_valid && result == $past(operand_a, 2))

endmodule

bind cpu_alu_flags_8bit caf8_checker u_caf8_checker (.*);

`default_nettype wire
